// ===== sv/pisdc_pkg.sv =====
// shared types, constants and codes of the pi speed and duty controller
package pisdc_pkg;

   localparam int DataW    = 16;
   localparam int FactorW  = 32;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 32;
   localparam int DivW     = 48;
   localparam int CountW   = $clog2(DivW);
   localparam int IntW     = 48;
   localparam int IpreW    = 50;
   localparam int PtermW   = 34;
   localparam int MulBW    = 35;
   localparam int ProdW    = 52;
   localparam int SumW     = 58;
   localparam int DutyRawW = 26;

   localparam logic [CountW-1:0] LastStep = CountW'(DivW - 1);

   localparam logic [FactorW-1:0] RstSpeedFactor = 32'd10000000;
   localparam logic [DataW-1:0]   RstKp           = 16'd655;
   localparam logic [DataW-1:0]   RstKi           = 16'd328;
   localparam logic [DataW-1:0]   RstIntegralMax  = 16'd1500;
   localparam logic [DataW-1:0]   RstIntegralMin  = 16'd300;
   localparam logic [DataW-1:0]   RstDutyMax      = 16'd1500;
   localparam logic [DataW-1:0]   RstDutyMin      = 16'd100;

   localparam logic signed [ProdW-1:0]    HugeA   = 52'sd1099511627776;
   localparam logic signed [DutyRawW-1:0] SatHigh = 26'sd70000;
   localparam logic signed [DutyRawW-1:0] SatLow  = -26'sd70000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SPEED_FACTOR = 3'd0,
      CSR_KP           = 3'd1,
      CSR_KI           = 3'd2,
      CSR_INTEGRAL_MAX = 3'd3,
      CSR_INTEGRAL_MIN = 3'd4,
      CSR_DUTY_MAX     = 3'd5,
      CSR_DUTY_MIN     = 3'd6
   } pisdc_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_SPEED,
      ST_MUL_P,
      ST_SUM,
      ST_MUL_HI,
      ST_MUL_LO,
      ST_DUTY,
      ST_CLAMP,
      ST_EMIT
   } pisdc_state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic speed;
      logic mul_p;
      logic sum;
      logic mul_hi;
      logic mul_lo;
      logic duty;
      logic clamp;
      logic emit;
   } pisdc_cmd_type;

   typedef struct packed {
      logic update;
   } pisdc_status_type;

endpackage

// ===== sv/pisdc_if.sv =====
// request and response channel interfaces
interface pisdc_req_if import pisdc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [DataW-1:0] period;
   logic [DataW-1:0] target_speed;
   logic             running;
   logic             loop_due;
   logic             restart;

   modport source (output valid, period, target_speed, running, loop_due, restart,
                   input ready);
   modport sink (input valid, period, target_speed, running, loop_due, restart,
                 output ready);
endinterface

interface pisdc_rsp_if import pisdc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [DataW-1:0] duty;
   logic [DataW-1:0] measured_speed;
   logic             updated;

   modport source (output valid, duty, measured_speed, updated, input ready);
   modport sink (input valid, duty, measured_speed, updated, output ready);
endinterface

// ===== sv/pi_speed_duty_control.sv =====
// top level of the pi speed loop producing a duty command
// usage:
//   req_chan carries one transaction per speed loop tick: commutation period,
//   target speed and the running, loop_due and restart flags. rsp_chan
//   returns exactly one transaction per request: duty, measured speed and
//   an updated flag. both are valid/ready channels. csr_* writes one
//   gain or limit register per cycle; the user must write only while
//   idle, and the block itself has no check for this.
// sequence:
//   a request that runs the loop passes through one 48-step restoring
//   division (speed and both integral bounds in parallel lanes), then
//   three passes through one shared multiplier and the clamp steps into
//   the response register; one that does not run the loop skips them.
//   one request is in work at a time; the next waits for writeback.
// reset:
//   synchronous; registers return to their default gains and limits,
//   the integral, held duty and held speed clear to zero.
// stall:
//   a finished response waits in an output register; the next request is
//   accepted meanwhile and is held back only at its own writeback.
module pi_speed_duty_control import pisdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   pisdc_req_if.sink           req_chan,
   pisdc_rsp_if.source         rsp_chan,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data
);

   pisdc_cmd_type    cmd;
   pisdc_status_type status;

   pisdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pisdc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_period         (req_chan.period),
      .req_target_speed   (req_chan.target_speed),
      .req_running        (req_chan.running),
      .req_loop_due       (req_chan.loop_due),
      .req_restart        (req_chan.restart),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_duty           (rsp_chan.duty),
      .rsp_measured_speed (rsp_chan.measured_speed),
      .rsp_updated        (rsp_chan.updated)
   );

endmodule

// ===== sv/pisdc_div.sv =====
// restoring divider, one quotient bit per step
module pisdc_div import pisdc_pkg::*; (
   input  logic             clock,
   input  logic             start,
   input  logic             step,
   input  logic [DivW-1:0]  dividend,
   input  logic [DataW-1:0] divisor,
   output logic [DivW-1:0]  quotient
);

   logic [DivW-1:0]  work_ff, work_in;
   logic [DataW-1:0] rem_ff, rem_in;
   logic [DataW:0]   rem_shift;
   logic [DataW:0]   rem_diff;
   logic             fits;

   always_comb begin
      rem_shift = {rem_ff, work_ff[DivW-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = rem_shift >= {1'b0, divisor};
      work_in   = work_ff;
      rem_in    = rem_ff;
      if (start) begin
         work_in = dividend;
         rem_in  = '0;
      end else if (step) begin
         work_in = {work_ff[DivW-2:0], fits};
         rem_in  = fits ? rem_diff[DataW-1:0] : rem_shift[DataW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient = work_ff;

endmodule

// ===== sv/pisdc_ctrl.sv =====
// sequencing state machine of the controller
module pisdc_ctrl import pisdc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  pisdc_status_type status,
   output pisdc_cmd_type    cmd
);

   pisdc_state_type   state_ff, state_in;
   logic [CountW-1:0] div_count_ff, div_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_START;
         ST_START:  state_in = status.update ? ST_DIV : ST_EMIT;
         ST_DIV:    if (div_count_ff == LastStep) state_in = ST_SPEED;
         ST_SPEED:  state_in = ST_MUL_P;
         ST_MUL_P:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_DUTY;
         ST_DUTY:   state_in = ST_CLAMP;
         ST_CLAMP:  state_in = ST_EMIT;
         ST_EMIT:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START:  cmd.div_start = status.update;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_SPEED:  cmd.speed = 1'b1;
         ST_MUL_P:  cmd.mul_p = 1'b1;
         ST_SUM:    cmd.sum = 1'b1;
         ST_MUL_HI: cmd.mul_hi = 1'b1;
         ST_MUL_LO: cmd.mul_lo = 1'b1;
         ST_DUTY:   cmd.duty = 1'b1;
         ST_CLAMP:  cmd.clamp = 1'b1;
         ST_EMIT:   cmd.emit = rsp_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      div_count_in = '0;
      if (state_ff == ST_DIV) begin
         div_count_in = div_count_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_count_ff <= div_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> rsp_free)
      else $error("result written over a transaction not yet taken");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("response valid without a result written");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_count_ff == LastStep) |=> state_ff == ST_SPEED)
      else $error("division did not end after its last step");
`endif

endmodule

// ===== sv/pisdc_datapath.sv =====
// registers, dividers, shared multiplier and clamps of the controller
module pisdc_datapath import pisdc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  pisdc_cmd_type       cmd,
   output pisdc_status_type    status,
   input  logic [DataW-1:0]    req_period,
   input  logic [DataW-1:0]    req_target_speed,
   input  logic                req_running,
   input  logic                req_loop_due,
   input  logic                req_restart,
   input  logic                csr_write_enable,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_write_data,
   output logic [DataW-1:0]    rsp_duty,
   output logic [DataW-1:0]    rsp_measured_speed,
   output logic                rsp_updated
);

   logic [FactorW-1:0] speed_factor_ff;
   logic [DataW-1:0]   kp_ff, ki_ff, imax_ff, imin_ff, duty_max_ff, duty_min_ff;

   logic [IntW-1:0]  integral_ff;
   logic [DataW-1:0] duty_hold_ff, speed_hold_ff;

   logic [DataW-1:0] period_ff, target_ff;
   logic             update_ff;

   logic [DataW-1:0] rsp_duty_ff, rsp_speed_ff;
   logic             rsp_updated_ff;

   logic signed [DataW:0]      err_ff;
   logic signed [ProdW-1:0]    prod_ff;
   logic signed [PtermW-1:0]   pterm_ff;
   logic signed [IpreW-1:0]    ipre_ff;
   logic signed [ProdW-1:0]    acc_ff;
   logic signed [DutyRawW-1:0] duty_raw_ff;

   logic [DivW-1:0]  speed_q, hi_b, lo_b;
   logic [DataW-1:0] ki_div;
   logic [DataW-1:0] spd;

   logic [DataW-1:0]           mul_a;
   logic signed [MulBW-1:0]    mul_b;
   logic signed [ProdW-1:0]    mul_prod;
   logic signed [SumW-1:0]     s_sum;
   logic signed [DutyRawW-1:0] v_trunc, v_in, dv;
   logic signed [IpreW-1:0]    ipre_sum, ipre_hi, ipre_lo;
   logic                       sat_hi, sat_lo;

   assign ki_div = (ki_ff == '0) ? DataW'(1) : ki_ff;

   pisdc_div u_speed_div (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend ({{(DivW-FactorW){1'b0}}, speed_factor_ff}),
      .divisor  (period_ff),
      .quotient (speed_q)
   );

   pisdc_div u_hi_div (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend ({imax_ff, {(DivW-DataW){1'b0}}}),
      .divisor  (ki_div),
      .quotient (hi_b)
   );

   pisdc_div u_lo_div (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend ({imin_ff, {(DivW-DataW){1'b0}}}),
      .divisor  (ki_div),
      .quotient (lo_b)
   );

   // speed saturates on a zero period or a quotient above 16 bits
   assign spd = (speed_q[DivW-1:DataW] != '0) ? '1 : speed_q[DataW-1:0];

   always_comb begin
      mul_a = ki_ff;
      mul_b = $signed({{(MulBW-DataW){1'b0}}, ipre_ff[DataW-1:0]});
      if (cmd.mul_p) begin
         mul_a = kp_ff;
         mul_b = $signed({{(MulBW-DataW-1){err_ff[DataW]}}, err_ff});
      end else if (cmd.mul_hi) begin
         mul_b = $signed({ipre_ff[IpreW-1], ipre_ff[IpreW-1:DataW]});
      end
   end

   assign mul_prod = $signed({1'b0, mul_a}) * mul_b;

   always_comb begin
      ipre_sum = $signed({{(IpreW-IntW){1'b0}}, integral_ff})
               + $signed({{(IpreW-PtermW){prod_ff[PtermW-1]}}, prod_ff[PtermW-1:0]});
      sat_hi = acc_ff >= HugeA;
      sat_lo = acc_ff <= -HugeA;
      s_sum  = $signed({acc_ff[SumW-DataW-1:0], {DataW{1'b0}}})
             + $signed({{(SumW-32){1'b0}}, prod_ff[31:0]});
      // truncate toward zero
      v_trunc = s_sum[SumW-1:32]
              + DutyRawW'(s_sum[SumW-1] && (s_sum[31:0] != '0));
      if (sat_hi) v_in = SatHigh;
      else if (sat_lo) v_in = SatLow;
      else v_in = v_trunc;
      ipre_hi = ipre_ff;
      if (ipre_ff > $signed({{(IpreW-DivW){1'b0}}, hi_b})) begin
         ipre_hi = $signed({{(IpreW-DivW){1'b0}}, hi_b});
      end
      ipre_lo = ipre_ff;
      if (ipre_ff < $signed({{(IpreW-DivW){1'b0}}, lo_b})) begin
         ipre_lo = $signed({{(IpreW-DivW){1'b0}}, lo_b});
      end
      dv = duty_raw_ff;
      if (dv >= $signed({{(DutyRawW-DataW){1'b0}}, duty_max_ff})) begin
         dv = $signed({{(DutyRawW-DataW){1'b0}}, duty_max_ff});
      end
      if (dv < $signed({{(DutyRawW-DataW){1'b0}}, duty_min_ff})) begin
         dv = $signed({{(DutyRawW-DataW){1'b0}}, duty_min_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_factor_ff <= RstSpeedFactor;
         kp_ff           <= RstKp;
         ki_ff           <= RstKi;
         imax_ff         <= RstIntegralMax;
         imin_ff         <= RstIntegralMin;
         duty_max_ff     <= RstDutyMax;
         duty_min_ff     <= RstDutyMin;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SPEED_FACTOR: speed_factor_ff <= csr_write_data;
            CSR_KP:           kp_ff <= csr_write_data[DataW-1:0];
            CSR_KI:           ki_ff <= csr_write_data[DataW-1:0];
            CSR_INTEGRAL_MAX: imax_ff <= csr_write_data[DataW-1:0];
            CSR_INTEGRAL_MIN: imin_ff <= csr_write_data[DataW-1:0];
            CSR_DUTY_MAX:     duty_max_ff <= csr_write_data[DataW-1:0];
            CSR_DUTY_MIN:     duty_min_ff <= csr_write_data[DataW-1:0];
            default:          speed_factor_ff <= speed_factor_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff   <= '0;
         duty_hold_ff  <= '0;
         speed_hold_ff <= '0;
      end else begin
         if (cmd.load && req_restart) integral_ff <= '0;
         if (cmd.clamp) integral_ff <= ipre_lo[IntW-1:0];
         if (cmd.clamp) duty_hold_ff <= dv[DataW-1:0];
         if (cmd.speed) speed_hold_ff <= spd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         period_ff <= req_period;
         target_ff <= req_target_speed;
         update_ff <= req_running && req_loop_due;
      end
      if (cmd.speed) err_ff <= $signed({1'b0, target_ff}) - $signed({1'b0, spd});
      if (cmd.mul_p || cmd.mul_hi || cmd.mul_lo) prod_ff <= mul_prod;
      if (cmd.sum) begin
         pterm_ff <= prod_ff[PtermW-1:0];
         ipre_ff  <= ipre_sum;
      end
      if (cmd.mul_lo) acc_ff <= $signed({{(ProdW-PtermW){pterm_ff[PtermW-1]}}, pterm_ff})
                               + prod_ff;
      if (cmd.duty) begin
         duty_raw_ff <= v_in;
         ipre_ff     <= ipre_hi;
      end
      if (cmd.emit) begin
         rsp_duty_ff    <= duty_hold_ff;
         rsp_speed_ff   <= speed_hold_ff;
         rsp_updated_ff <= update_ff;
      end
   end

   assign status.update      = update_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_measured_speed = rsp_speed_ff;
   assign rsp_updated        = rsp_updated_ff;

`ifndef SYNTHESIS
   a_integral_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |=> integral_ff >= $past(lo_b))
      else $error("integral below its lower bound after clamp");

   a_duty_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.clamp |=> duty_hold_ff >= $past(duty_min_ff))
      else $error("duty below its lower limit after clamp");

   a_zero_period: assert property (@(posedge clock) disable iff (reset)
      (cmd.speed && period_ff == '0) |=> speed_hold_ff == '1)
      else $error("zero period did not saturate the speed");
`endif

endmodule
